// ===== rtl/dashed_line_quad_generator_top_macros.svh =====
// assertion helpers for the rtl
`ifndef DASHED_LINE_QUAD_GENERATOR_TOP_MACROS_SVH
`define DASHED_LINE_QUAD_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, clocked on clock, quiet during reset
`define DLQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DLQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dlq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dlq_pkg;

   // field and datapath widths
   localparam int IN_W       = 16;
   localparam int W_W        = 12;
   localparam int FILL_W     = 9;
   localparam int DIFF_W     = 17;
   localparam int SQ_W       = 34;
   localparam int ROOT_W     = 17;
   localparam int SREM_W     = 19;
   localparam int SQRT_STEPS = 17;
   localparam int DIV_NUM_W  = 30;
   localparam int DIV_STEPS  = 30;
   localparam int QUO_W      = 16;
   localparam int PERIOD_W   = 14;
   localparam int DRAWN_W    = 15;
   localparam int T_W        = 21;
   localparam int CNT_W      = 6;
   localparam int STEP_W     = 5;
   localparam int PROD_W     = 38;
   localparam int WIDE_W     = 40;
   localparam int UNIT_SHIFT = 14;
   localparam int OFF_SHIFT  = 15;
   localparam int LANES      = 3;
   localparam int LANE_X     = 0;
   localparam int LANE_Y     = 1;
   localparam int LANE_N     = 2;

   localparam logic [FILL_W-1:0] FILL_FULL  = 9'd256;
   localparam logic [FILL_W-1:0] FILL_RESET = 9'd128;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_SCALE,
      ST_OFFSET,
      ST_DASH_MUL,
      ST_DASH_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic square;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic scale;
      logic offset;
      logic dash_mul;
      logic out_load;
      logic dash_next;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic last;
   } status_type;

   // signed shift right by s with rounding half away from zero
   function automatic logic signed [WIDE_W-1:0] round_shift(
      input logic signed [WIDE_W-1:0] v, input int s);
      logic [WIDE_W-1:0] mag;
      mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
      mag = (mag + (WIDE_W'(1) << (s - 1))) >> s;
      return v[WIDE_W-1] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dlq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// segment input channel
interface dlq_req_if;
   logic                     valid;
   logic                     ready;
   logic signed [15:0]       start_x;
   logic signed [15:0]       start_y;
   logic signed [15:0]       end_x;
   logic signed [15:0]       end_y;
   logic        [11:0]       line_width;
   modport source (output valid, start_x, start_y, end_x, end_y, line_width, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, line_width, output ready);
endinterface

// quad result channel
interface dlq_rsp_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] corner0_x;
   logic signed [COORD_BITS-1:0] corner0_y;
   logic signed [COORD_BITS-1:0] corner1_x;
   logic signed [COORD_BITS-1:0] corner1_y;
   logic signed [COORD_BITS-1:0] corner2_x;
   logic signed [COORD_BITS-1:0] corner2_y;
   logic signed [COORD_BITS-1:0] corner3_x;
   logic signed [COORD_BITS-1:0] corner3_y;
   logic                         last_dash;
   logic                         clipped;
   modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
                   corner2_y, corner3_x, corner3_y, last_dash, clipped, input ready);
   modport sink   (input valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
                   corner2_y, corner3_x, corner3_y, last_dash, clipped, output ready);
endinterface

// dash_fill register write channel
interface dlq_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dlq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "dashed_line_quad_generator_top_macros.svh"
module dlq_ctrl
   import dlq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SQUARE;
         ST_SQUARE:   state_in = ST_SQRT;
         ST_SQRT:     if (step_ff == STEP_W'(SQRT_STEPS - 1)) state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = status.len_zero ? ST_SCALE : ST_DIV;
         ST_DIV:      if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_OFFSET;
         ST_OFFSET:   state_in = ST_DASH_MUL;
         ST_DASH_MUL: state_in = ST_DASH_OUT;
         ST_DASH_OUT: if (out_free) state_in = status.last ? ST_IDLE : ST_DASH_MUL;
         default:     state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQUARE:   cmd.square    = 1'b1;
         ST_SQRT:     cmd.sqrt_step = 1'b1;
         ST_DIV_INIT: cmd.div_init  = 1'b1;
         ST_DIV:      cmd.div_step  = 1'b1;
         ST_SCALE:    cmd.scale     = 1'b1;
         ST_OFFSET:   cmd.offset    = 1'b1;
         ST_DASH_MUL: cmd.dash_mul  = 1'b1;
         ST_DASH_OUT: begin
            cmd.out_load  = out_free;
            cmd.dash_next = out_free && !status.last;
         end
         default: cmd = '0;
      endcase
   end

   // iteration counter and output valid
   always_comb begin
      step_in      = (state_ff == ST_SQRT || state_ff == ST_DIV) ? step_ff + 1'b1 : '0;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DLQ_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_SQUARE, "accepted segment did not start")
   `DLQ_ASSERT_NEXT(a_quad_shown, state_ff == ST_DASH_OUT && out_free, rsp_valid_ff, "loaded quad not presented")
   `DLQ_ASSERT_NOW(a_sqrt_bound, state_ff == ST_SQRT, step_ff < STEP_W'(SQRT_STEPS), "root iteration overran")

endmodule
`default_nettype wire

// ===== rtl/dlq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dlq_datapath
   import dlq_pkg::*;
#(
   parameter int MAX_DASHES = 63,
   parameter int COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cmd_type                      cmd,
   output status_type                        status,
   input  wire logic                         csr_we,
   input  wire logic [FILL_W-1:0]            csr_data,
   input  wire logic signed [IN_W-1:0]       start_x,
   input  wire logic signed [IN_W-1:0]       start_y,
   input  wire logic signed [IN_W-1:0]       end_x,
   input  wire logic signed [IN_W-1:0]       end_y,
   input  wire logic [W_W-1:0]               line_width,
   output logic signed [COORD_BITS-1:0]      corner0_x,
   output logic signed [COORD_BITS-1:0]      corner0_y,
   output logic signed [COORD_BITS-1:0]      corner1_x,
   output logic signed [COORD_BITS-1:0]      corner1_y,
   output logic signed [COORD_BITS-1:0]      corner2_x,
   output logic signed [COORD_BITS-1:0]      corner2_y,
   output logic signed [COORD_BITS-1:0]      corner3_x,
   output logic signed [COORD_BITS-1:0]      corner3_y,
   output logic                              last_dash,
   output logic                              clipped
);

   localparam logic signed [WIDE_W-1:0] C_HI = (WIDE_W'(1) <<< (COORD_BITS - 1)) - 1;
   localparam logic signed [WIDE_W-1:0] C_LO = -C_HI - 1;

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = (v > C_HI) ? C_HI : ((v < C_LO) ? C_LO : v);
      return c[COORD_BITS-1:0];
   endfunction

   // configuration register
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_eff;
   always_ff @(posedge clock) begin
      if (reset) fill_ff <= FILL_RESET;
      else if (csr_we) fill_ff <= csr_data;
   end
   assign fill_eff = (fill_ff > FILL_FULL) ? FILL_FULL : fill_ff;

   // segment capture
   logic signed [IN_W-1:0]   org_x_ff, org_y_ff;
   logic [IN_W-1:0]          adx_ff, ady_ff;
   logic                     negx_ff, negy_ff;
   logic [W_W-1:0]           w_ff;
   logic signed [DIFF_W-1:0] dx, dy;
   assign dx = DIFF_W'(end_x) - DIFF_W'(start_x);
   assign dy = DIFF_W'(end_y) - DIFF_W'(start_y);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         org_x_ff <= start_x;
         org_y_ff <= start_y;
         negx_ff  <= dx[DIFF_W-1];
         negy_ff  <= dy[DIFF_W-1];
         adx_ff   <= dx[DIFF_W-1] ? IN_W'(-dx) : IN_W'(dx);
         ady_ff   <= dy[DIFF_W-1] ? IN_W'(-dy) : IN_W'(dy);
         w_ff     <= line_width;
      end
   end

   // squared length and bit-pair square root
   logic [SQ_W-1:0]   sq_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SREM_W-1:0] srem_ff;
   logic [SREM_W+1:0] srem_sh, strial;
   assign srem_sh = {srem_ff, sq_ff[SQ_W-1 -: 2]};
   assign strial  = (SREM_W+2)'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_ff   <= SQ_W'(adx_ff * adx_ff) + SQ_W'(ady_ff * ady_ff);
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sq_ff <= sq_ff << 2;
         if (srem_sh >= strial) begin
            srem_ff <= SREM_W'(srem_sh - strial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= SREM_W'(srem_sh);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   logic                len_zero;
   logic [PERIOD_W-1:0] period;
   assign len_zero = (root_ff == '0);
   assign period   = {w_ff, 2'b00};

   // three restoring divider lanes: x and y direction, dash count
   logic [DIV_NUM_W-1:0] num_ff  [LANES];
   logic [ROOT_W-1:0]    drem_ff [LANES];
   logic [QUO_W-1:0]     quo_ff  [LANES];
   logic [ROOT_W-1:0]    dvsr    [LANES];
   assign dvsr[LANE_X] = root_ff;
   assign dvsr[LANE_Y] = root_ff;
   assign dvsr[LANE_N] = ROOT_W'(period);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [ROOT_W:0] rsh;
      logic            ge;
      assign rsh = {drem_ff[g], num_ff[g][DIV_NUM_W-1]};
      assign ge  = rsh >= {1'b0, dvsr[g]};
      always_ff @(posedge clock) begin
         if (cmd.div_init) begin
            drem_ff[g] <= '0;
            quo_ff[g]  <= '0;
            unique case (g)
               LANE_X:  num_ff[g] <= {adx_ff, UNIT_SHIFT'(0)};
               LANE_Y:  num_ff[g] <= {ady_ff, UNIT_SHIFT'(0)};
               default: num_ff[g] <= DIV_NUM_W'(root_ff);
            endcase
         end else if (cmd.div_step) begin
            num_ff[g]  <= num_ff[g] << 1;
            drem_ff[g] <= ge ? ROOT_W'(rsh - {1'b0, dvsr[g]}) : rsh[ROOT_W-1:0];
            quo_ff[g]  <= {quo_ff[g][QUO_W-2:0], ge};
         end
      end
   end

   // direction, dash count, drawn length
   logic signed [QUO_W-1:0]   ux_ff, uy_ff;
   logic [CNT_W-1:0]          total_ff, index_ff;
   logic                      clip_ff;
   logic [DRAWN_W-1:0]        drawn_ff;
   logic [T_W-1:0]            t0_ff;
   logic                      over;
   logic [PERIOD_W+FILL_W-1:0] drawn_prod;
   assign over       = quo_ff[LANE_N] > QUO_W'(MAX_DASHES);
   assign drawn_prod = period * fill_eff;

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         ux_ff    <= len_zero ? '0 : (negx_ff ? -quo_ff[LANE_X] : quo_ff[LANE_X]);
         uy_ff    <= len_zero ? '0 : (negy_ff ? -quo_ff[LANE_Y] : quo_ff[LANE_Y]);
         if (len_zero || period == '0) begin
            total_ff <= '0;
            clip_ff  <= 1'b0;
         end else begin
            total_ff <= over ? CNT_W'(MAX_DASHES) : CNT_W'(quo_ff[LANE_N]);
            clip_ff  <= over;
         end
         drawn_ff <= DRAWN_W'(drawn_prod >> 8);
         t0_ff    <= '0;
         index_ff <= '0;
      end else if (cmd.dash_next) begin
         t0_ff    <= t0_ff + T_W'(period);
         index_ff <= index_ff + 1'b1;
      end
   end

   assign status.len_zero = len_zero;
   assign status.last     = (index_ff == total_ff);

   // half-width normal offset
   logic signed [WIDE_W-1:0] offx_ff, offy_ff;
   logic signed [W_W:0]      ws;
   assign ws = $signed({1'b0, w_ff});
   always_ff @(posedge clock) begin
      if (cmd.offset) begin
         offx_ff <= round_shift(-WIDE_W'(uy_ff * ws), OFF_SHIFT);
         offy_ff <= round_shift(WIDE_W'(ux_ff * ws), OFF_SHIFT);
      end
   end

   // dash end distance and products along the direction
   logic [T_W-1:0]           tsum, t1;
   logic signed [T_W:0]      t0s, t1s;
   logic signed [PROD_W-1:0] px0_ff, py0_ff, px1_ff, py1_ff;
   logic                     last_ff;
   assign tsum = t0_ff + T_W'(drawn_ff);
   assign t1   = (status.last && tsum > T_W'(root_ff)) ? T_W'(root_ff) : tsum;
   assign t0s  = $signed({1'b0, t0_ff});
   assign t1s  = $signed({1'b0, t1});
   always_ff @(posedge clock) begin
      if (cmd.dash_mul) begin
         px0_ff  <= PROD_W'(ux_ff * t0s);
         py0_ff  <= PROD_W'(uy_ff * t0s);
         px1_ff  <= PROD_W'(ux_ff * t1s);
         py1_ff  <= PROD_W'(uy_ff * t1s);
         last_ff <= status.last;
      end
   end

   // corners and output register
   logic signed [WIDE_W-1:0] ax, ay, bx, by;
   assign ax = WIDE_W'(org_x_ff) + round_shift(WIDE_W'(px0_ff), UNIT_SHIFT);
   assign ay = WIDE_W'(org_y_ff) + round_shift(WIDE_W'(py0_ff), UNIT_SHIFT);
   assign bx = WIDE_W'(org_x_ff) + round_shift(WIDE_W'(px1_ff), UNIT_SHIFT);
   assign by = WIDE_W'(org_y_ff) + round_shift(WIDE_W'(py1_ff), UNIT_SHIFT);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         corner0_x <= sat_coord(ax - offx_ff);
         corner0_y <= sat_coord(ay - offy_ff);
         corner1_x <= sat_coord(ax + offx_ff);
         corner1_y <= sat_coord(ay + offy_ff);
         corner2_x <= sat_coord(bx + offx_ff);
         corner2_y <= sat_coord(by + offy_ff);
         corner3_x <= sat_coord(bx - offx_ff);
         corner3_y <= sat_coord(by - offy_ff);
         last_dash <= last_ff;
         clipped   <= clip_ff;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/dashed_line_quad_generator_top.sv =====
// Dashed thick line tessellation.
// req_bus takes one segment per transaction (start, end, integer width);
// rsp_bus returns its quads in order, one transaction each, the final one
// with last_dash set. csr_bus writes dash_fill and is always ready; the user
// must write it only while no segment is in flight; nothing enforces it.
// One segment at a time: an idle step to accept, a squaring step, the
// bit-pair square root, loading the three restoring divider lanes and
// 30 divider steps (the steps are skipped for a zero length), then
// scaling and offset, then per quad the products and the output
// register; a new segment is taken once the final quad sits in the
// output register.
// Reset clears the controller to idle, drops rsp valid and sets dash_fill
// to 128. A stalled receiver holds the output register and its quad; the
// sequencer waits in its output step until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module dashed_line_quad_generator_top
   import dlq_pkg::*;
#(
   parameter int MAX_DASHES = 63,
   parameter int COORD_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dlq_req_if.sink    req_bus,
   dlq_rsp_if.source  rsp_bus,
   dlq_csr_if.sink    csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   // sequencer
   dlq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   dlq_datapath #(
      .MAX_DASHES (MAX_DASHES),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_bus.valid),
      .csr_data   (csr_bus.data),
      .start_x    (req_bus.start_x),
      .start_y    (req_bus.start_y),
      .end_x      (req_bus.end_x),
      .end_y      (req_bus.end_y),
      .line_width (req_bus.line_width),
      .corner0_x  (rsp_bus.corner0_x),
      .corner0_y  (rsp_bus.corner0_y),
      .corner1_x  (rsp_bus.corner1_x),
      .corner1_y  (rsp_bus.corner1_y),
      .corner2_x  (rsp_bus.corner2_x),
      .corner2_y  (rsp_bus.corner2_y),
      .corner3_x  (rsp_bus.corner3_x),
      .corner3_y  (rsp_bus.corner3_y),
      .last_dash  (rsp_bus.last_dash),
      .clipped    (rsp_bus.clipped)
   );

endmodule
`default_nettype wire

// ===== tb/dashed_line_quad_generator_top_tb.sv =====
`timescale 1ns / 1ps
module dashed_line_quad_generator_top_tb;
   import dlq_pkg::*;

   localparam int MAX_DASH_CNT = 63;
   localparam int CBITS        = 16;
   localparam int SEG_LATENCY  = 200;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic signed [15:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
      logic               last_dash;
      logic               clipped;
   } quad_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlq_req_if             req_bus ();
   dlq_rsp_if #(.COORD_BITS(CBITS)) rsp_bus ();
   dlq_csr_if             csr_bus ();

   dashed_line_quad_generator_top #(.MAX_DASHES(MAX_DASH_CNT), .COORD_BITS(CBITS)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // predictor state
   int unsigned fill_reg = 128;
   quad_type    quad_queue[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   longint      cycle_count = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dashed_line_quad_generator_top_tb: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > n) bit_val >>= 2;
      while (bit_val != 0) begin
         if (n >= root + bit_val) begin
            n -= root + bit_val;
            root = (root >> 1) + bit_val;
         end else begin
            root >>= 1;
         end
         bit_val >>= 2;
      end
      return root;
   endfunction

   function automatic longint shift_round(input longint v, input int s);
      longint unsigned m;
      m = v < 0 ? -v : v;
      m = (m + (64'd1 << (s - 1))) >> s;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [15:0] sat_coord(input longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // expected quads of one segment
   task automatic predict_quads(input logic signed [15:0] sx, sy, ex, ey,
                                input logic [11:0] w);
      longint dx, dy, ux, uy, ox, oy, ax, ay, bx, by;
      longint unsigned adx, ady, len, period, n, drawn, t0, t1;
      int unsigned fill;
      bit clip;
      quad_type q;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      fill = fill_reg > 256 ? 256 : fill_reg;
      len = int_sqrt(adx * adx + ady * ady);
      period = 4 * w;
      clip = 0;
      if (len == 0) begin
         q = '{sx, sy, sx, sy, sx, sy, sx, sy, 1'b1, 1'b0};
         quad_queue.push_back(q);
         return;
      end
      ux = longint'((adx << 14) / len);
      uy = longint'((ady << 14) / len);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
      ox = shift_round(-uy * longint'(w), 15);
      oy = shift_round(ux * longint'(w), 15);
      n = period == 0 ? 0 : len / period;
      if (n > MAX_DASH_CNT) begin
         n = MAX_DASH_CNT;
         clip = 1;
      end
      drawn = (period * fill) >> 8;
      for (longint unsigned i = 0; i <= n; i++) begin
         t0 = i * period;
         t1 = t0 + drawn;
         if (i == n && t1 > len) t1 = len;
         ax = longint'(sx) + shift_round(ux * longint'(t0), 14);
         ay = longint'(sy) + shift_round(uy * longint'(t0), 14);
         bx = longint'(sx) + shift_round(ux * longint'(t1), 14);
         by = longint'(sy) + shift_round(uy * longint'(t1), 14);
         q.c0x = sat_coord(ax - ox);
         q.c0y = sat_coord(ay - oy);
         q.c1x = sat_coord(ax + ox);
         q.c1y = sat_coord(ay + oy);
         q.c2x = sat_coord(bx + ox);
         q.c2y = sat_coord(by + oy);
         q.c3x = sat_coord(bx - ox);
         q.c3y = sat_coord(by - oy);
         q.last_dash = (i == n);
         q.clipped = clip;
         quad_queue.push_back(q);
      end
   endtask

   // driver defaults
   initial begin
      req_bus.valid = 1'b0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x = '0;
      req_bus.end_y = '0;
      req_bus.line_width = 12'd1;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
   end

   // receiver ready, changed on the falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      quad_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.corner0_x, rsp_bus.corner0_y, rsp_bus.corner1_x,
                 rsp_bus.corner1_y, rsp_bus.corner2_x, rsp_bus.corner2_y,
                 rsp_bus.corner3_x, rsp_bus.corner3_y, rsp_bus.last_dash,
                 rsp_bus.clipped};
         if (quad_queue.size() == 0) begin
            report_mismatch("unexpected quad", 1, 0);
         end else begin
            want = quad_queue.pop_front();
            if (got.c0x !== want.c0x) report_mismatch("corner0_x", got.c0x, want.c0x);
            if (got.c0y !== want.c0y) report_mismatch("corner0_y", got.c0y, want.c0y);
            if (got.c1x !== want.c1x) report_mismatch("corner1_x", got.c1x, want.c1x);
            if (got.c1y !== want.c1y) report_mismatch("corner1_y", got.c1y, want.c1y);
            if (got.c2x !== want.c2x) report_mismatch("corner2_x", got.c2x, want.c2x);
            if (got.c2y !== want.c2y) report_mismatch("corner2_y", got.c2y, want.c2y);
            if (got.c3x !== want.c3x) report_mismatch("corner3_x", got.c3x, want.c3x);
            if (got.c3y !== want.c3y) report_mismatch("corner3_y", got.c3y, want.c3y);
            if (got.last_dash !== want.last_dash)
               report_mismatch("last_dash", got.last_dash, want.last_dash);
            if (got.clipped !== want.clipped)
               report_mismatch("clipped", got.clipped, want.clipped);
         end
      end
   end

   // one segment transaction, valid is low on entry and on return
   task automatic send_segment(input logic signed [15:0] sx, sy, ex, ey,
                               input logic [11:0] w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.start_x <= sx;
      req_bus.start_y <= sy;
      req_bus.end_x <= ex;
      req_bus.end_y <= ey;
      req_bus.line_width <= w;
      do @(posedge clock); while (!req_bus.ready);
      predict_quads(sx, sy, ex, ey, w);
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (quad_queue.size() != 0) @(negedge clock);
      repeat (SEG_LATENCY) @(negedge clock);
   endtask

   // register write while idle
   task automatic write_fill(input logic [8:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      fill_reg = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_directed();
      send_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd16);
      send_segment(16'sd100, -16'sd50, 16'sd100, -16'sd50, 12'd4095);
      send_segment(16'sd0, 16'sd0, 16'sd1000, 16'sd0, 12'd16);
      send_segment(16'sd0, 16'sd0, 16'sd0, -16'sd1000, 12'd16);
      send_segment(16'sd10, 16'sd20, -16'sd700, 16'sd500, 12'd33);
      send_segment(16'sd0, 16'sd0, 16'sd30, 16'sd40, 12'd1);
      send_segment(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 12'd1);
      send_segment(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 12'd4095);
      send_segment(16'sd32767, 16'sd32767, 16'sd32000, 16'sd32767, 12'd4095);
      send_segment(-16'sd32768, 16'sd0, -16'sd32700, 16'sd0, 12'd2048);
      send_segment(16'sd0, 16'sd0, 16'sd5, 16'sd0, 12'd4095);
      send_segment(16'sd0, 16'sd0, 16'sd64, 16'sd0, 12'd4);
   endtask

   task automatic test_fill_settings();
      logic [8:0] fills[5] = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd300};
      foreach (fills[k]) begin
         write_fill(fills[k]);
         send_segment(16'sd0, 16'sd0, 16'sd900, 16'sd300, 12'd20);
         send_segment(16'sd5, 16'sd5, -16'sd20000, 16'sd100, 12'd4000);
         send_segment(16'sd0, 16'sd0, 16'sd3, 16'sd4, 12'd1);
      end
   endtask

   task automatic random_segment();
      logic signed [15:0] sx, sy, ex, ey;
      logic [11:0] w;
      sx = $urandom;
      sy = $urandom;
      case ($urandom_range(3))
         0: begin
            ex = $urandom;
            ey = $urandom;
         end
         1: begin
            ex = sx + $signed(16'($urandom_range(4000))) - 16'sd2000;
            ey = sy + $signed(16'($urandom_range(4000))) - 16'sd2000;
         end
         2: begin
            ex = sx;
            ey = sy;
         end
         default: begin
            ex = sx + $signed(16'($urandom_range(200))) - 16'sd100;
            ey = sy;
         end
      endcase
      w = ($urandom_range(3) == 0) ? 12'($urandom_range(1, 4095)) :
                                      12'($urandom_range(1, 64));
      send_segment(sx, sy, ex, ey, w);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         random_segment();
         if (i == count / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_settings();
      write_fill(9'd128);
      send_idle_pct = 23;
      recv_idle_pct = 53;
      test_random(25);
      send_idle_pct = 53;
      recv_idle_pct = 23;
      test_random(25);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_fill(9'($urandom_range(0, 511)));
      test_random(25);
      wait_drained();
      if (error_count == 0) begin
         $display("dashed_line_quad_generator_top_tb: PASS");
      end else begin
         $display("dashed_line_quad_generator_top_tb: FAIL");
      end
      $finish;
   end

endmodule
